[src/pbst_pkg.sv]
// ----------------------------------------------------------------------------
// Page buffer slot table package
// Shared request, result and slot entry types, and the operation and status
// codes used across the slot table.
// ----------------------------------------------------------------------------
`default_nettype none

package pbst_pkg;

  // Operation codes carried by a request
  localparam logic [1:0] OP_REQUEST = 2'd0;
  localparam logic [1:0] OP_RELEASE = 2'd1;
  localparam logic [1:0] OP_CLEAR   = 2'd2;

  // Result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;

  // Disk kinds that have a read counter of their own
  localparam logic [1:0] KIND_SSD = 2'd0;
  localparam logic [1:0] KIND_HDD = 2'd1;

  // Field widths
  localparam int unsigned PAGE_BYTES_W = 17;
  localparam int unsigned SLOT_W       = 6;
  localparam int unsigned OFFSET_W     = 22;
  localparam int unsigned COUNT_W      = 32;

  localparam logic [PAGE_BYTES_W-1:0] PAGE_BYTES_RESET = 17'd4096;
  localparam logic [COUNT_W-1:0]      COUNT_MAX        = 32'hFFFF_FFFF;

  // One input request
  typedef struct packed {
    logic [1:0]  operation;
    logic [31:0] page_id;
    logic [3:0]  disk_id;
    logic [1:0]  disk_kind;
  } pbst_in_t;

  // One result
  typedef struct packed {
    logic                  hit;
    logic [1:0]            status;
    logic [SLOT_W-1:0]     slot;
    logic [OFFSET_W-1:0]   byte_offset;
    logic [COUNT_W-1:0]    total_reads;
    logic [COUNT_W-1:0]    ssd_reads;
    logic [COUNT_W-1:0]    hdd_reads;
  } pbst_out_t;

  // One stored slot
  typedef struct packed {
    logic        valid;
    logic [31:0] page_id;
    logic [3:0]  disk_id;
  } pbst_entry_t;

endpackage

`default_nettype wire

[src/pbst_mem.sv]
// ----------------------------------------------------------------------------
// Slot store
// Single write port, single registered read port memory holding one entry
// (valid flag, page and disk) per slot.
// ----------------------------------------------------------------------------
`default_nettype none

module pbst_mem #(
  parameter int unsigned DEPTH  = 64,
  parameter int unsigned ADDR_W = 6
) (
  input  wire logic                 clk,
  input  wire logic                 wr_en,
  input  wire logic [ADDR_W-1:0]    wr_addr,
  input  wire pbst_pkg::pbst_entry_t wr_data,
  input  wire logic                 rd_en,
  input  wire logic [ADDR_W-1:0]    rd_addr,
  output pbst_pkg::pbst_entry_t     rd_data
);

  pbst_pkg::pbst_entry_t mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

[src/pbst_scan.sv]
// ----------------------------------------------------------------------------
// Slot scan unit
// Compares one slot entry a cycle against the request key and keeps the
// lowest matching slot and the lowest free slot seen since the last start.
// ----------------------------------------------------------------------------
`default_nettype none

module pbst_scan #(
  parameter int unsigned IDX_W = 6
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  input  wire logic                  en,
  input  wire logic [IDX_W-1:0]      idx,
  input  wire pbst_pkg::pbst_entry_t entry,
  input  wire logic [31:0]           key_page,
  input  wire logic [3:0]            key_disk,
  output logic                       match_found,
  output logic [IDX_W-1:0]           match_idx,
  output logic                       free_found,
  output logic [IDX_W-1:0]           free_idx
);

  logic is_match;
  logic is_free;

  // Shared comparator for the entry being scanned
  always_comb begin
    is_match = en && entry.valid && (entry.page_id == key_page) &&
               (entry.disk_id == key_disk);
    is_free  = en && !entry.valid;
  end

  // Keep only the first match and the first free slot
  always_ff @(posedge clk) begin
    if (rst || start) begin
      match_found <= 1'b0;
      free_found  <= 1'b0;
    end else begin
      if (is_match && !match_found) begin
        match_found <= 1'b1;
      end
      if (is_free && !free_found) begin
        free_found <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (is_match && !match_found) begin
      match_idx <= idx;
    end
    if (is_free && !free_found) begin
      free_idx <= idx;
    end
  end

endmodule

`default_nettype wire

[src/page_buffer_slot_table_unit.sv]
// ----------------------------------------------------------------------------
// Page buffer slot table
// Fully associative table of page slots with first free allocation and
// saturating disk read counters.
// ----------------------------------------------------------------------------
// Usage
// The input channel (in_valid, in_stall, in_req) carries one request: a page
// request, a page release or a clear of all slots. The output channel
// (out_valid, out_stall, out_rsp) returns exactly one result per request.
// The user writes page size through cfg_wr_en and cfg_wr_data only while
// idle; the block itself does not enforce this. A request or release scans
// the slot store one entry a cycle through a single compare unit: the scan
// reads every entry, a last step compares the last entry and an update step
// follows, and then the result is loaded. A clear sweeps the store one
// entry a cycle. The next request is taken only once the result is loaded
// and the block is idle again, so one request at a time passes through the
// single read port of the slot store. After reset a clearing pass over all
// slots runs before the first request is accepted. The result sits in an
// output register: a new request is taken while it waits, and a stalled
// receiver holds the block only when the next result is ready to load.
// ----------------------------------------------------------------------------
`default_nettype none

module page_buffer_slot_table_unit #(
  parameter int unsigned SLOTS = 64
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   in_valid,
  output logic                                        in_stall,
  input  wire pbst_pkg::pbst_in_t                     in_req,
  output logic                                        out_valid,
  input  wire logic                                   out_stall,
  output pbst_pkg::pbst_out_t                         out_rsp,
  input  wire logic                                   cfg_wr_en,
  input  wire logic [pbst_pkg::PAGE_BYTES_W-1:0]      cfg_wr_data
);

  localparam int unsigned IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned PROD_W = IDX_W + pbst_pkg::OFFSET_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

  typedef enum logic [5:0] {
    ST_CLEAR  = 6'b000001,
    ST_IDLE   = 6'b000010,
    ST_SCAN   = 6'b000100,
    ST_LAST   = 6'b001000,
    ST_UPDATE = 6'b010000,
    ST_RESULT = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;

  pbst_pkg::pbst_in_t req;
  logic [pbst_pkg::PAGE_BYTES_W-1:0] page_bytes;
  logic [IDX_W-1:0] clr_cnt;
  logic             clr_op;
  logic [IDX_W-1:0] scan_cnt;
  logic             scan_vld;
  logic [IDX_W-1:0] scan_idx;

  logic [pbst_pkg::COUNT_W-1:0] read_total;
  logic [pbst_pkg::COUNT_W-1:0] read_ssd;
  logic [pbst_pkg::COUNT_W-1:0] read_hdd;

  logic             res_hit;
  logic [1:0]       res_status;
  logic [IDX_W-1:0] res_idx;

  logic                  mem_wr_en;
  logic [IDX_W-1:0]      mem_wr_addr;
  pbst_pkg::pbst_entry_t mem_wr_data;
  logic                  mem_rd_en;
  pbst_pkg::pbst_entry_t mem_rd_data;

  logic             match_found;
  logic [IDX_W-1:0] match_idx;
  logic             free_found;
  logic [IDX_W-1:0] free_idx;

  logic accept;
  logic start;
  logic alloc;
  logic release_hit;
  logic load_out;
  logic [IDX_W+pbst_pkg::SLOT_W-1:0] slot_wide;
  logic [PROD_W-1:0] product;

  function automatic logic [pbst_pkg::COUNT_W-1:0] sat_inc(
    input logic [pbst_pkg::COUNT_W-1:0] v
  );
    logic [pbst_pkg::COUNT_W-1:0] r;
    r = (v == pbst_pkg::COUNT_MAX) ? v : v + 1'b1;
    return r;
  endfunction

  // Slot store and shared compare unit
  pbst_mem #(
    .DEPTH  (SLOTS),
    .ADDR_W (IDX_W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (scan_cnt),
    .rd_data (mem_rd_data)
  );

  pbst_scan #(
    .IDX_W (IDX_W)
  ) u_scan (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .en          (scan_vld),
    .idx         (scan_idx),
    .entry       (mem_rd_data),
    .key_page    (req.page_id),
    .key_disk    (req.disk_id),
    .match_found (match_found),
    .match_idx   (match_idx),
    .free_found  (free_found),
    .free_idx    (free_idx)
  );

  // Handshake and decision terms
  always_comb begin
    in_stall    = (state != ST_IDLE);
    accept      = in_valid && !in_stall;
    start       = accept;
    mem_rd_en   = (state == ST_SCAN);
    alloc       = (req.operation == pbst_pkg::OP_REQUEST) && !match_found && free_found;
    release_hit = (req.operation == pbst_pkg::OP_RELEASE) && match_found;
    load_out    = (state == ST_RESULT) && (!out_valid || !out_stall);
  end

  // Slot store write port: clearing sweep, allocation or release
  always_comb begin
    mem_wr_en   = 1'b0;
    mem_wr_addr = clr_cnt;
    mem_wr_data = '0;
    if (state == ST_CLEAR) begin
      mem_wr_en = 1'b1;
    end else if (state == ST_UPDATE) begin
      mem_wr_data.page_id = req.page_id;
      mem_wr_data.disk_id = req.disk_id;
      if (alloc) begin
        mem_wr_en         = 1'b1;
        mem_wr_addr       = free_idx;
        mem_wr_data.valid = 1'b1;
      end else if (release_hit) begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = match_idx;
      end
    end
  end

  // Sequencer next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_cnt == LAST_IDX) begin
          state_next = clr_op ? ST_RESULT : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          if (in_req.operation == pbst_pkg::OP_CLEAR) begin
            state_next = ST_CLEAR;
          end else if (in_req.operation == pbst_pkg::OP_REQUEST ||
                       in_req.operation == pbst_pkg::OP_RELEASE) begin
            state_next = ST_SCAN;
          end else begin
            state_next = ST_RESULT;
          end
        end
      end
      ST_SCAN: begin
        if (scan_cnt == LAST_IDX) begin
          state_next = ST_LAST;
        end
      end
      ST_LAST: begin
        state_next = ST_UPDATE;
      end
      ST_UPDATE: begin
        state_next = ST_RESULT;
      end
      ST_RESULT: begin
        if (load_out) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      clr_cnt    <= '0;
      clr_op     <= 1'b0;
      scan_cnt   <= '0;
      scan_vld   <= 1'b0;
      page_bytes <= pbst_pkg::PAGE_BYTES_RESET;
      read_total <= '0;
      read_ssd   <= '0;
      read_hdd   <= '0;
      out_valid  <= 1'b0;
    end else begin
      state    <= state_next;
      scan_vld <= (state == ST_SCAN);
      if (cfg_wr_en) begin
        page_bytes <= cfg_wr_data;
      end
      if (state == ST_CLEAR) begin
        clr_cnt <= clr_cnt + 1'b1;
      end else if (accept) begin
        clr_cnt <= '0;
        clr_op  <= 1'b1;
      end
      if (state == ST_SCAN) begin
        scan_cnt <= scan_cnt + 1'b1;
      end else if (accept) begin
        scan_cnt <= '0;
      end
      if (state == ST_UPDATE && alloc) begin
        read_total <= sat_inc(read_total);
        if (req.disk_kind == pbst_pkg::KIND_SSD) begin
          read_ssd <= sat_inc(read_ssd);
        end else if (req.disk_kind == pbst_pkg::KIND_HDD) begin
          read_hdd <= sat_inc(read_hdd);
        end
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Request capture and result fields
  always_ff @(posedge clk) begin
    scan_idx <= scan_cnt;
    if (accept) begin
      req        <= in_req;
      res_hit    <= 1'b0;
      res_status <= pbst_pkg::ST_OK;
      res_idx    <= '0;
    end
    if (state == ST_UPDATE) begin
      if (req.operation == pbst_pkg::OP_REQUEST) begin
        if (match_found) begin
          res_hit <= 1'b1;
          res_idx <= match_idx;
        end else if (free_found) begin
          res_idx <= free_idx;
        end else begin
          res_status <= pbst_pkg::ST_FULL;
        end
      end else if (match_found) begin
        res_idx <= match_idx;
      end else begin
        res_status <= pbst_pkg::ST_NOT_FOUND;
      end
    end
  end

  // Byte offset and slot field of the result
  always_comb begin
    slot_wide = {{pbst_pkg::SLOT_W{1'b0}}, res_idx};
    product   = PROD_W'(res_idx) * PROD_W'(page_bytes);
  end

  // Output register
  always_ff @(posedge clk) begin
    if (load_out) begin
      out_rsp.hit         <= res_hit;
      out_rsp.status      <= res_status;
      out_rsp.slot        <= slot_wide[pbst_pkg::SLOT_W-1:0];
      out_rsp.byte_offset <= product[pbst_pkg::OFFSET_W-1:0];
      out_rsp.total_reads <= read_total;
      out_rsp.ssd_reads   <= read_ssd;
      out_rsp.hdd_reads   <= read_hdd;
    end
  end

  // The slot store is only read, never written, while a scan runs.
  a_no_write_in_scan: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> !mem_wr_en)
    else $error("slot store written during scan");

  // Per-kind counters never run ahead of the total.
  a_kind_le_total: assert property (@(posedge clk) disable iff (rst)
    (read_ssd <= read_total) && (read_hdd <= read_total))
    else $error("kind read counter exceeds total");

  // The total changes only in the update step.
  a_total_on_update: assert property (@(posedge clk) disable iff (rst)
    ($past(!rst) && (read_total != $past(read_total))) |-> $past(state == ST_UPDATE))
    else $error("read total changed outside update");

  // A hit result always reports status ok.
  a_hit_ok: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_rsp.hit) |-> (out_rsp.status == pbst_pkg::ST_OK))
    else $error("hit reported with error status");

endmodule

`default_nettype wire

[tb/sv/tb.sv]
// ----------------------------------------------------------------------------
// Page buffer slot table testbench
// Drives page requests, releases and clears into the slot table, keeps a
// shadow of the slot store and the read counters, and checks every result
// field by field. Page size is changed between phases while the table is
// quiet, and both channels idle and stall at varying rates.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned NUM_SLOTS       = 64;
  localparam int unsigned POOL_SIZE       = 96;
  localparam int unsigned ITEMS_PER_PHASE = 82;
  localparam int unsigned NUM_PHASES      = 6;
  localparam int unsigned HOLD_CYCLES     = 400;
  localparam int unsigned DRAIN_CYCLES    = 80;
  localparam int unsigned QUIET_LIMIT     = 5000;

  // Operation and disk kind codes that the package leaves unnamed
  localparam logic [1:0] OP_UNUSED  = 2'd3;
  localparam logic [1:0] KIND_OTHER = 2'd2;
  localparam logic [1:0] KIND_SPARE = 2'd3;

  // Shadow of the slot table: predicts each result and checks it on arrival.
  class slot_table_tracker;
    bit                                resident[NUM_SLOTS];
    bit [31:0]                         held_page[NUM_SLOTS];
    bit [3:0]                          held_disk[NUM_SLOTS];
    bit [pbst_pkg::COUNT_W-1:0]        reads_total;
    bit [pbst_pkg::COUNT_W-1:0]        reads_ssd;
    bit [pbst_pkg::COUNT_W-1:0]        reads_hdd;
    bit [pbst_pkg::PAGE_BYTES_W-1:0]   page_bytes;
    pbst_pkg::pbst_out_t               awaited[$];
    int unsigned                       errors;

    function new();
      foreach (resident[k]) resident[k] = 1'b0;
      reads_total = '0;
      reads_ssd   = '0;
      reads_hdd   = '0;
      page_bytes  = pbst_pkg::PAGE_BYTES_RESET;
      errors      = 0;
    endfunction

    function void set_page_bytes(bit [pbst_pkg::PAGE_BYTES_W-1:0] value);
      page_bytes = value;
    endfunction

    function int unsigned outstanding();
      return awaited.size();
    endfunction

    function bit [pbst_pkg::COUNT_W-1:0] bump(bit [pbst_pkg::COUNT_W-1:0] count);
      return (count == pbst_pkg::COUNT_MAX) ? count : count + 1'b1;
    endfunction

    // Lowest resident slot holding the pair, or -1.
    function int find_pair(bit [31:0] page, bit [3:0] disk);
      for (int k = 0; k < NUM_SLOTS; k++) begin
        if (resident[k] && held_page[k] == page && held_disk[k] == disk) return k;
      end
      return -1;
    endfunction

    function int find_free();
      for (int k = 0; k < NUM_SLOTS; k++) begin
        if (!resident[k]) return k;
      end
      return -1;
    endfunction

    // Slot index and its byte offset, wrapped to the offset width.
    function pbst_pkg::pbst_out_t slot_result(int k);
      pbst_pkg::pbst_out_t r;
      bit [31:0] product;
      r = '0;
      r.slot = k[pbst_pkg::SLOT_W-1:0];
      product = 32'(k) * 32'(page_bytes);
      r.byte_offset = product[pbst_pkg::OFFSET_W-1:0];
      return r;
    endfunction

    // Apply an accepted request to the shadow and queue the result it causes.
    function void take_request(pbst_pkg::pbst_in_t q);
      pbst_pkg::pbst_out_t r;
      int k;
      r = '0;
      case (q.operation)
        pbst_pkg::OP_REQUEST: begin
          k = find_pair(q.page_id, q.disk_id);
          if (k >= 0) begin
            r = slot_result(k);
            r.hit = 1'b1;
          end else begin
            k = find_free();
            if (k >= 0) begin
              resident[k]  = 1'b1;
              held_page[k] = q.page_id;
              held_disk[k] = q.disk_id;
              reads_total  = bump(reads_total);
              if (q.disk_kind == pbst_pkg::KIND_SSD) reads_ssd = bump(reads_ssd);
              else if (q.disk_kind == pbst_pkg::KIND_HDD) reads_hdd = bump(reads_hdd);
              r = slot_result(k);
            end else begin
              r.status = pbst_pkg::ST_FULL;
            end
          end
        end
        pbst_pkg::OP_RELEASE: begin
          k = find_pair(q.page_id, q.disk_id);
          if (k >= 0) begin
            resident[k] = 1'b0;
            r = slot_result(k);
          end else begin
            r.status = pbst_pkg::ST_NOT_FOUND;
          end
        end
        pbst_pkg::OP_CLEAR: begin
          foreach (resident[j]) resident[j] = 1'b0;
        end
        default: begin
        end
      endcase
      r.total_reads = reads_total;
      r.ssd_reads   = reads_ssd;
      r.hdd_reads   = reads_hdd;
      awaited.push_back(r);
    endfunction

    function void compare(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
      end
    endfunction

    // Compare a delivered result with the oldest prediction.
    function void check_result(pbst_pkg::pbst_out_t got);
      pbst_pkg::pbst_out_t want;
      if (awaited.size() == 0) begin
        errors++;
        $display("%0t: result %h arrived with no request outstanding", $time, got);
        return;
      end
      want = awaited.pop_front();
      compare("hit", 64'(want.hit), 64'(got.hit));
      compare("status", 64'(want.status), 64'(got.status));
      compare("slot", 64'(want.slot), 64'(got.slot));
      compare("byte_offset", 64'(want.byte_offset), 64'(got.byte_offset));
      compare("total_reads", 64'(want.total_reads), 64'(got.total_reads));
      compare("ssd_reads", 64'(want.ssd_reads), 64'(got.ssd_reads));
      compare("hdd_reads", 64'(want.hdd_reads), 64'(got.hdd_reads));
    endfunction
  endclass

  logic                              clk         = 1'b0;
  logic                              rst         = 1'b1;
  logic                              in_valid    = 1'b0;
  logic                              in_stall;
  pbst_pkg::pbst_in_t                in_req      = '0;
  logic                              out_valid;
  logic                              out_stall   = 1'b0;
  pbst_pkg::pbst_out_t               out_rsp;
  logic                              cfg_wr_en   = 1'b0;
  logic [pbst_pkg::PAGE_BYTES_W-1:0] cfg_wr_data = '0;

  slot_table_tracker sb;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_order     = 0;
  int unsigned hold_left      = 0;
  int unsigned quiet_cycles   = 0;
  bit          in_fire;
  bit          out_fire;
  bit [31:0]   pool_page[POOL_SIZE];
  bit [3:0]    pool_disk[POOL_SIZE];

  page_buffer_slot_table_unit #(.SLOTS(NUM_SLOTS)) dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_req     (in_req),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_rsp    (out_rsp),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Receiver: a requested hold-off is counted down here, otherwise random stalls.
  always @(negedge clk) begin
    if (hold_order != 0) begin
      hold_left  = hold_order;
      hold_order = 0;
    end
    if (hold_left != 0) begin
      out_stall = 1'b1;
      hold_left--;
    end else begin
      out_stall = ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  // Both handshakes are observed at the rising edge; a long silence ends the run.
  always @(posedge clk) begin
    if (!rst) begin
      in_fire  = in_valid && (in_stall === 1'b0);
      out_fire = (out_valid === 1'b1) && !out_stall;
      if (in_fire) sb.take_request(in_req);
      if (out_fire) sb.check_result(out_rsp);
      if (in_fire || out_fire) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  function automatic pbst_pkg::pbst_in_t make_item(logic [1:0] op, logic [31:0] page,
                                                   logic [3:0] disk, logic [1:0] kind);
    pbst_pkg::pbst_in_t q;
    q.operation = op;
    q.page_id   = page;
    q.disk_id   = disk;
    q.disk_kind = kind;
    return q;
  endfunction

  // Mostly requests and releases over a pool of pairs, so that the table fills,
  // hits, frees slots; else fresh pairs, absent releases, unused ops, clears.
  function automatic pbst_pkg::pbst_in_t random_item();
    int unsigned pick;
    int unsigned idx;
    logic [1:0]  kind;
    pick = $urandom_range(0, 99);
    idx  = $urandom_range(0, POOL_SIZE - 1);
    kind = 2'($urandom_range(0, 3));
    if (pick < 60) begin
      return make_item(pbst_pkg::OP_REQUEST, pool_page[idx], pool_disk[idx], kind);
    end
    if (pick < 80) begin
      return make_item(pbst_pkg::OP_RELEASE, pool_page[idx], pool_disk[idx], kind);
    end
    if (pick < 88) begin
      // A fresh pair sometimes shares its page with the pair it replaces.
      if ($urandom_range(0, 3) != 0) pool_page[idx] = $urandom();
      pool_disk[idx] = 4'($urandom_range(0, 15));
      return make_item(pbst_pkg::OP_REQUEST, pool_page[idx], pool_disk[idx], kind);
    end
    if (pick < 93) begin
      return make_item(pbst_pkg::OP_RELEASE, $urandom(), 4'($urandom_range(0, 15)), kind);
    end
    if (pick < 97) return make_item(OP_UNUSED, $urandom(), 4'($urandom_range(0, 15)), kind);
    return make_item(pbst_pkg::OP_CLEAR, $urandom(), 4'($urandom_range(0, 15)), kind);
  endfunction

  // Offer one request, with random idle cycles first, and hold it until taken.
  task automatic send(pbst_pkg::pbst_in_t q);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_req   = q;
    do @(posedge clk); while (in_stall !== 1'b0);
    @(negedge clk);
  endtask

  // Stop offering and wait until every predicted result has been delivered.
  task automatic settle();
    in_valid = 1'b0;
    while (sb.outstanding() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_page_bytes(logic [pbst_pkg::PAGE_BYTES_W-1:0] value);
    settle();
    cfg_wr_en   = 1'b1;
    cfg_wr_data = value;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    sb.set_page_bytes(value);
  endtask

  initial begin
    int unsigned idle_plan[NUM_PHASES]  = '{0, 81, 0, 38, 0, 38};
    int unsigned stall_plan[NUM_PHASES] = '{0, 0, 81, 38, 0, 38};
    logic [pbst_pkg::PAGE_BYTES_W-1:0] size_plan[NUM_PHASES] =
      '{17'd1, 17'd65536, 17'h1FFFF, 17'd4096, 17'd0, 17'd4096};
    sb = new();
    foreach (pool_page[i]) begin
      pool_page[i] = $urandom();
      pool_disk[i] = 4'($urandom_range(0, 15));
    end
    pool_page[0] = 32'h0000_0000;
    pool_page[1] = 32'hFFFF_FFFF;
    pool_page[3] = pool_page[2];
    pool_disk[3] = ~pool_disk[2];

    repeat (10) @(negedge clk);
    rst = 1'b0;

    // Directed opening at the reset page size: extremes, hits, same page on
    // another disk, lowest free reuse, absent release, unused operation, clear.
    send(make_item(pbst_pkg::OP_REQUEST, 32'h0000_0000, 4'h0, pbst_pkg::KIND_SSD));
    send(make_item(pbst_pkg::OP_REQUEST, 32'h0000_0000, 4'h0, pbst_pkg::KIND_SSD));
    send(make_item(pbst_pkg::OP_REQUEST, 32'hFFFF_FFFF, 4'hF, pbst_pkg::KIND_HDD));
    send(make_item(pbst_pkg::OP_REQUEST, 32'h0000_0000, 4'h1, KIND_OTHER));
    send(make_item(pbst_pkg::OP_REQUEST, 32'hFFFF_FFFF, 4'h0, KIND_SPARE));
    send(make_item(pbst_pkg::OP_REQUEST, 32'hFFFF_FFFF, 4'hF, pbst_pkg::KIND_SSD));
    send(make_item(pbst_pkg::OP_RELEASE, 32'h0000_0000, 4'h0, pbst_pkg::KIND_SSD));
    send(make_item(pbst_pkg::OP_RELEASE, 32'h0000_0000, 4'h0, pbst_pkg::KIND_HDD));
    send(make_item(pbst_pkg::OP_REQUEST, 32'h5A5A_A5A5, 4'h9, pbst_pkg::KIND_HDD));
    send(make_item(pbst_pkg::OP_RELEASE, 32'hFFFF_FFFF, 4'h0, pbst_pkg::KIND_SSD));
    send(make_item(OP_UNUSED, 32'hFFFF_FFFF, 4'hF, KIND_SPARE));
    send(make_item(pbst_pkg::OP_CLEAR, 32'hFFFF_FFFF, 4'hF, KIND_SPARE));
    send(make_item(pbst_pkg::OP_RELEASE, 32'h5A5A_A5A5, 4'h9, KIND_OTHER));
    send(make_item(pbst_pkg::OP_REQUEST, 32'h0000_0000, 4'h1, pbst_pkg::KIND_SSD));
    send(make_item(pbst_pkg::OP_REQUEST, 32'hA5A5_5A5A, 4'h6, KIND_OTHER));

    // Random phases, each first setting its page size and idling mix.
    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p == 3) write_page_bytes(pbst_pkg::PAGE_BYTES_W'($urandom_range(2, 65535)));
      else write_page_bytes(size_plan[p]);
      send_idle_pct  = idle_plan[p];
      recv_stall_pct = stall_plan[p];
      // Hold the receiver off early on so the table backs up into its input.
      if (p == 0) hold_order = HOLD_CYCLES;
      repeat (ITEMS_PER_PHASE) send(random_item());
    end

    settle();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (sb.errors == 0 && sb.outstanding() == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end
endmodule

[filelist.f]
src/pbst_pkg.sv
src/pbst_mem.sv
src/pbst_scan.sv
src/page_buffer_slot_table_unit.sv
tb/sv/tb.sv
